// ===== design/text_console_writer_macros.svh =====
// Assertion macros shared by the text console writer RTL.
// Expects a clock named clk and an active-high reset named rst in scope.
`ifndef TEXT_CONSOLE_WRITER_MACROS_SVH
`define TEXT_CONSOLE_WRITER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== design/tcw_pkg.sv =====
// Shared types, constants and tables for the text console writer.
// No dependencies; used by text_console_writer.sv.
`timescale 1ns / 1ps

package tcw_pkg;

  // Screen geometry
  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int TAB_STOP   = 8;
  localparam int CELL_COUNT = COLUMNS * ROWS;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int CELL_W = $clog2(CELL_COUNT);

  localparam int CHAR_W      = 8;
  localparam int ATTR_W      = 8;
  localparam int CELL_DATA_W = CHAR_W + ATTR_W;
  localparam int OP_W        = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = ATTR_W;

  localparam int SCROLL_LAST = CELL_COUNT - COLUMNS;

  typedef logic [CELL_W-1:0]      cell_addr_t;
  typedef logic [CELL_DATA_W-1:0] cell_t;

  typedef enum logic [OP_W-1:0] {
    OP_PUT   = 2'd0,
    OP_CLEAR = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CHAR_ATTR  = 1'b0,
    REG_BLANK_ATTR = 1'b1
  } cfg_reg_t;

  typedef enum logic [4:0] {
    ST_INIT   = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_READ   = 5'b00100,
    ST_SCROLL = 5'b01000,
    ST_FILL   = 5'b10000
  } state_t;

  // Control characters and printable range
  localparam logic [CHAR_W-1:0] CH_BS        = 8'h08;
  localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CHAR_W-1:0] CH_PRINT_MAX = 8'h7F;

  localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'd15;
  localparam cell_t             RESET_BLANK = {RESET_ATTR, CH_SPACE};

  // Next tab stop for every column, built at elaboration
  typedef logic [COLUMNS-1:0][COL_W:0] tab_table_t;

  function automatic tab_table_t build_tab_next();
    tab_table_t t;
    for (int i = 0; i < COLUMNS; i++) begin
      t[i] = (COL_W + 1)'(i + TAB_STOP - (i % TAB_STOP));
    end
    return t;
  endfunction

  localparam tab_table_t TAB_NEXT = build_tab_next();

endpackage

// ===== design/tcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/text_console_writer.sv =====
// Text console writer top level: cursor logic, sequencer and screen store.
// Depends on tcw_pkg, tcw_ram and text_console_writer_macros.svh.
`timescale 1ns / 1ps
// Sequence: a put without scroll is done in the cycle after start; a read passes through READ;
//   a clear walks FILL over every cell; a put with scroll walks SCROLL, then FILL.
// Throughput: one word at a time; busy stays high while the shared address counter
//   walks the store through its single write port (clear, scroll, reset sweep).
// Reset: after rst the block sweeps all CELL_COUNT cells to blank (space, attribute 15)
//   with busy high; config writes are taken during the sweep. Results cannot be stalled.

`include "text_console_writer_macros.svh"

module text_console_writer (
  input  logic                                clk,
  input  logic                                rst,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [tcw_pkg::OP_W-1:0]            operation,
  input  logic [tcw_pkg::CHAR_W-1:0]          char_code,
  input  logic [tcw_pkg::CELL_W-1:0]          cell_index,
  // result channel
  output logic                                done,
  output logic [tcw_pkg::COL_W-1:0]           cursor_col,
  output logic [tcw_pkg::ROW_W-1:0]           cursor_row,
  output logic [tcw_pkg::CELL_W-1:0]          cursor_position,
  output logic [tcw_pkg::CELL_DATA_W-1:0]     cell_data,
  // configuration write port
  input  logic                                cfg_we,
  input  logic [tcw_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tcw_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int COL_W  = tcw_pkg::COL_W;
  localparam int ROW_W  = tcw_pkg::ROW_W;

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  tcw_pkg::state_t            state, state_next;
  tcw_pkg::cell_addr_t        cnt, cnt_next;        // shared sweep/copy address counter
  logic [COL_W-1:0]           cursor_column, column_next;
  logic [ROW_W-1:0]           cursor_line, line_next;
  logic [tcw_pkg::ATTR_W-1:0] char_attribute, blank_attribute;
  logic                       done_next;
  tcw_pkg::cell_t             cell_data_next;

  // Screen store ports
  logic                       ram_we;
  tcw_pkg::cell_addr_t        ram_waddr, ram_raddr;
  tcw_pkg::cell_t             ram_wdata, ram_rdata;

  tcw_pkg::cell_addr_t        pos_now;
  tcw_pkg::cell_t             blank;

  // Linear address of the cursor; line and column always stay on screen here.
  assign pos_now = tcw_pkg::cell_addr_t'(cursor_line) * tcw_pkg::cell_addr_t'(tcw_pkg::COLUMNS)
                 + tcw_pkg::cell_addr_t'(cursor_column);
  assign blank   = {blank_attribute, tcw_pkg::CH_SPACE};

  // ---------------------------------------------------------------------------
  // Put-character decode: new cursor, print enable and scroll request
  // ---------------------------------------------------------------------------
  logic [COL_W:0] put_col;
  logic [ROW_W:0] put_line;
  logic           put_print;
  logic           put_scroll;

  always_comb begin
    put_col   = {1'b0, cursor_column};
    put_line  = {1'b0, cursor_line};
    put_print = 1'b0;
    priority if (char_code == tcw_pkg::CH_BS) begin
      // hold at column 0
      if (cursor_column != '0) put_col = put_col - 1'b1;
    end else if (char_code == tcw_pkg::CH_TAB) begin
      put_col = tcw_pkg::TAB_NEXT[cursor_column];
    end else if (char_code == tcw_pkg::CH_CR) begin
      put_col = '0;
    end else if (char_code == tcw_pkg::CH_LF) begin
      put_col  = '0;
      put_line = put_line + 1'b1;
    end else if (char_code >= tcw_pkg::CH_SPACE && char_code <= tcw_pkg::CH_PRINT_MAX) begin
      put_print = 1'b1;
      put_col   = put_col + 1'b1;
    end else begin
      // drop anything else
      put_print = 1'b0;
    end
    // wrap past the last column
    if (put_col >= (COL_W + 1)'(tcw_pkg::COLUMNS)) begin
      put_col  = '0;
      put_line = put_line + 1'b1;
    end
    put_scroll = (put_line >= (ROW_W + 1)'(tcw_pkg::ROWS));
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  //   INIT   : sweep reset blanks into every cell
  //   IDLE   : take a command; a put finishes here unless it scrolls
  //   READ   : registered read data arrives
  //   SCROLL : copy cell cnt+COLUMNS to cnt, one per cycle, write lags the registered read
  //   FILL   : write blanks from cnt up to the last cell
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next     = state;
    cnt_next       = cnt;
    column_next    = cursor_column;
    line_next      = cursor_line;
    done_next      = 1'b0;
    cell_data_next = '0;
    ram_we         = 1'b0;
    ram_waddr      = cnt;
    ram_wdata      = blank;
    ram_raddr      = cell_index;

    unique case (state)
      tcw_pkg::ST_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = tcw_pkg::RESET_BLANK;
        if (cnt == tcw_pkg::cell_addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
          cnt_next   = '0;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tcw_pkg::ST_IDLE: begin
        if (start) begin
          unique case (operation)
            tcw_pkg::OP_PUT: begin
              ram_we      = put_print;
              ram_waddr   = pos_now;
              ram_wdata   = {char_attribute, char_code};
              column_next = put_col[COL_W-1:0];
              if (put_scroll) begin
                // cursor parks on the bottom row; the store shifts up afterwards
                line_next  = ROW_W'(tcw_pkg::ROWS - 1);
                cnt_next   = '0;
                state_next = tcw_pkg::ST_SCROLL;
              end else begin
                line_next = put_line[ROW_W-1:0];
                done_next = 1'b1;
              end
            end
            tcw_pkg::OP_CLEAR: begin
              column_next = '0;
              line_next   = '0;
              cnt_next    = '0;
              state_next  = tcw_pkg::ST_FILL;
            end
            tcw_pkg::OP_READ: begin
              if ({1'b0, cell_index} < (tcw_pkg::CELL_W + 1)'(tcw_pkg::CELL_COUNT)) begin
                state_next = tcw_pkg::ST_READ;
              end else begin
                done_next = 1'b1;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end

      tcw_pkg::ST_READ: begin
        cell_data_next = ram_rdata;
        done_next      = 1'b1;
        state_next     = tcw_pkg::ST_IDLE;
      end

      tcw_pkg::ST_SCROLL: begin
        ram_raddr = cnt + tcw_pkg::cell_addr_t'(tcw_pkg::COLUMNS);
        ram_we    = (cnt != '0);
        ram_waddr = cnt - 1'b1;
        ram_wdata = ram_rdata;
        if (cnt == tcw_pkg::cell_addr_t'(tcw_pkg::SCROLL_LAST)) begin
          // last copy lands now; cnt already points at the bottom row
          state_next = tcw_pkg::ST_FILL;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      tcw_pkg::ST_FILL: begin
        ram_we = 1'b1;
        if (cnt == tcw_pkg::cell_addr_t'(tcw_pkg::CELL_COUNT - 1)) begin
          state_next = tcw_pkg::ST_IDLE;
          cnt_next   = '0;
          done_next  = 1'b1;
        end else begin
          cnt_next = cnt + 1'b1;
        end
      end

      default: begin
        state_next = tcw_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= tcw_pkg::ST_INIT;
      cnt             <= '0;
      cursor_column   <= '0;
      cursor_line     <= '0;
      done            <= 1'b0;
      char_attribute  <= tcw_pkg::RESET_ATTR;
      blank_attribute <= tcw_pkg::RESET_ATTR;
    end else begin
      state         <= state_next;
      cnt           <= cnt_next;
      cursor_column <= column_next;
      cursor_line   <= line_next;
      done          <= done_next;
      if (cfg_we) begin
        unique case (cfg_index)
          tcw_pkg::REG_CHAR_ATTR:  char_attribute  <= cfg_data;
          tcw_pkg::REG_BLANK_ATTR: blank_attribute <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // Cell data is a payload register: zero unless the word carries a read.
  always_ff @(posedge clk) begin
    cell_data <= cell_data_next;
  end

  // ---------------------------------------------------------------------------
  // Screen store
  // ---------------------------------------------------------------------------
  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_DATA_W),
    .DEPTH(tcw_pkg::CELL_COUNT)
  ) u_screen (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign busy            = (state != tcw_pkg::ST_IDLE);
  assign cursor_col      = cursor_column;
  assign cursor_row      = cursor_line;
  assign cursor_position = pos_now;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  logic cursor_ok;
  logic scroll_write;

  assign cursor_ok    = (cursor_line < ROW_W'(tcw_pkg::ROWS))
                      && ({1'b0, cursor_column} < (COL_W + 1)'(tcw_pkg::COLUMNS));
  assign scroll_write = (state == tcw_pkg::ST_SCROLL) && ram_we;

  `TCW_ASSERT(a_done_idle, done |-> !busy, "result strobe while sequencer busy")
  `TCW_ASSERT(a_accept_moves, (start && !busy) |=> (done || busy), "accepted word went nowhere")
  `TCW_ASSERT(a_cursor_on_screen, cursor_ok, "cursor off screen")
  `TCW_ASSERT(a_scroll_no_overlap, scroll_write |-> (ram_waddr != ram_raddr), "scroll copy clash")
  `TCW_ASSERT_ALWAYS(a_reset_busy, rst |=> (busy && !done), "block idle right after reset")

endmodule
